// ----- sv/csvfs_pkg.sv -----
// ----------------------------------------------------------------------------
// csvfs_pkg
// shared byte type and fixed byte codes for the csv field splitter
// ----------------------------------------------------------------------------
package csvfs_pkg;

  typedef logic [7:0] byte_t;

  // fixed byte codes
  localparam byte_t QUOTE_BYTE        = 8'd34;
  localparam byte_t NEWLINE_BYTE      = 8'd10;
  localparam byte_t DEFAULT_SEPARATOR = 8'd44;

endpackage

// ----- sv/csvfs_channels.sv -----
// ----------------------------------------------------------------------------
// csvfs channels
// valid/ready channels for text bytes, split results and separator writes
// ----------------------------------------------------------------------------

// text byte channel
interface csvfs_byte_if;
  logic             valid;
  logic             ready;
  csvfs_pkg::byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// split result channel
interface csvfs_result_if;
  logic             valid;
  logic             ready;
  csvfs_pkg::byte_t out_byte;
  logic             byte_valid;
  logic             field_end;
  logic             line_end;

  modport source (output valid, output out_byte, output byte_valid, output field_end,
                  output line_end, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input field_end,
                input line_end, output ready);
endinterface

// separator register write channel
interface csvfs_cfg_if;
  logic             valid;
  logic             ready;
  csvfs_pkg::byte_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/csv_field_splitter_unit.sv -----
// ----------------------------------------------------------------------------
// csv_field_splitter_unit
// streaming splitter of comma-separated text lines into fields
// ----------------------------------------------------------------------------
// One text byte is taken per request and at most one result comes out of it,
// in the cycle after acceptance, through a single result register. A byte can be
// accepted every clock cycle: the input is ready whenever the result register
// is empty or is being drained in the same cycle, so while a result is stalled
// the input is held off until it drains. Separators split fields outside
// quotes, newline ends the line and the last field, quoted fields lose their
// enclosing quotes and doubled quotes collapse to one. The separator register
// (comma after reset) is always ready and should be written only while the
// block is idle.
module csv_field_splitter_unit (
  input  logic                   clk,
  input  logic                   rst,
  csvfs_byte_if.sink             src,
  csvfs_result_if.source         res,
  csvfs_cfg_if.sink              cfg
);

  // parser state
  csvfs_pkg::byte_t separator;
  logic             quote_mode;
  logic             at_field_start;
  logic             enclosed_field;
  logic             quote_waiting;

  logic             quote_mode_next;
  logic             at_field_start_next;
  logic             enclosed_field_next;
  logic             quote_waiting_next;

  // result register
  logic             res_valid;
  csvfs_pkg::byte_t res_byte;
  logic             res_byte_valid;
  logic             res_field_end;
  logic             res_line_end;

  logic             emit;
  csvfs_pkg::byte_t emit_byte;
  logic             emit_byte_valid;
  logic             emit_field_end;
  logic             emit_line_end;
  logic             mode_after_quote;
  logic             accept;

  assign cfg.ready = 1'b1;
  assign src.ready = !res_valid || res.ready;
  assign accept    = src.valid && src.ready;

  assign res.valid      = res_valid;
  assign res.out_byte   = res_byte;
  assign res.byte_valid = res_byte_valid;
  assign res.field_end  = res_field_end;
  assign res.line_end   = res_line_end;

  // per-byte decode
  always_comb begin
    quote_mode_next     = quote_mode;
    at_field_start_next = at_field_start;
    enclosed_field_next = enclosed_field;
    quote_waiting_next  = quote_waiting;
    emit                = 1'b0;
    emit_byte           = '0;
    emit_byte_valid     = 1'b0;
    emit_field_end      = 1'b0;
    emit_line_end       = 1'b0;
    // a single waiting quote toggles quote mode once a non-quote follows
    mode_after_quote    = quote_waiting ? !quote_mode : quote_mode;

    if (src.in_byte == csvfs_pkg::QUOTE_BYTE) begin
      if (at_field_start) begin
        quote_mode_next     = 1'b1;
        enclosed_field_next = 1'b1;
        at_field_start_next = 1'b0;
      end else if (quote_waiting) begin
        quote_waiting_next = 1'b0;
        emit               = 1'b1;
        emit_byte          = csvfs_pkg::QUOTE_BYTE;
        emit_byte_valid    = 1'b1;
      end else begin
        quote_waiting_next = 1'b1;
        emit               = !enclosed_field;
        emit_byte          = enclosed_field ? '0 : csvfs_pkg::QUOTE_BYTE;
        emit_byte_valid    = !enclosed_field;
      end
    end else begin
      quote_waiting_next = 1'b0;
      quote_mode_next    = mode_after_quote;
      emit               = 1'b1;
      if (src.in_byte == csvfs_pkg::NEWLINE_BYTE) begin
        quote_mode_next     = 1'b0;
        at_field_start_next = 1'b1;
        enclosed_field_next = 1'b0;
        emit_field_end      = 1'b1;
        emit_line_end       = 1'b1;
      end else if (src.in_byte == separator && !mode_after_quote) begin
        at_field_start_next = 1'b1;
        enclosed_field_next = 1'b0;
        emit_field_end      = 1'b1;
      end else begin
        at_field_start_next = 1'b0;
        emit_byte           = src.in_byte;
        emit_byte_valid     = 1'b1;
      end
    end
  end

  // state and separator register
  always_ff @(posedge clk) begin
    if (rst) begin
      separator      <= csvfs_pkg::DEFAULT_SEPARATOR;
      quote_mode     <= 1'b0;
      at_field_start <= 1'b1;
      enclosed_field <= 1'b0;
      quote_waiting  <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        separator <= cfg.data;
      end
      if (accept) begin
        quote_mode     <= quote_mode_next;
        at_field_start <= at_field_start_next;
        enclosed_field <= enclosed_field_next;
        quote_waiting  <= quote_waiting_next;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= emit;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_byte       <= emit_byte;
      res_byte_valid <= emit_byte_valid;
      res_field_end  <= emit_field_end;
      res_line_end   <= emit_line_end;
    end
  end

  // newline always closes the line in the next result
  a_newline_ends_line: assert property (@(posedge clk) disable iff (rst)
    accept && src.in_byte == csvfs_pkg::NEWLINE_BYTE
      |=> res_valid && res_line_end && res_field_end && !res_byte_valid)
    else $error("newline did not give a line end");

  // an opening quote gives no result
  a_open_quote_silent: assert property (@(posedge clk) disable iff (rst)
    accept && src.in_byte == csvfs_pkg::QUOTE_BYTE && at_field_start |=> !res_valid)
    else $error("opening quote produced a result");

  // a pending quote never coexists with a field start
  a_wait_not_start: assert property (@(posedge clk) disable iff (rst)
    quote_waiting |-> !at_field_start)
    else $error("quote pending at field start");

  // field boundaries carry no content byte
  a_end_no_content: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_field_end |-> !res_byte_valid && res_byte == '0)
    else $error("field end carries content");

  // line end implies field end
  a_line_has_field: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_line_end |-> res_field_end)
    else $error("line end without field end");

endmodule

// ----- sim/csv_field_splitter_unit_checker.sv -----
// ----------------------------------------------------------------------------
// csv_field_splitter_unit_checker
// watches the byte, result and separator channels, predicts every split
// result from the accepted text bytes and compares it field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csv_field_splitter_unit_checker (
  input  logic     clk,
  input  logic     rst,
  csvfs_byte_if    src,
  csvfs_result_if  res,
  csvfs_cfg_if     cfg,
  output int       fail_count,
  output int       results_owed
);

  typedef struct packed {
    csvfs_pkg::byte_t out_byte;
    logic             byte_valid;
    logic             field_end;
    logic             line_end;
  } split_result_t;

  // predicted splitter state
  csvfs_pkg::byte_t separator;
  logic             quote_mode;
  logic             at_field_start;
  logic             enclosed_field;
  logic             quote_waiting;

  split_result_t expected_results[$];
  int            mismatches;

  // advance the splitter state by one text byte, returns 1 when a result is due
  function automatic bit split_byte(input csvfs_pkg::byte_t b, output split_result_t r);
    r = '0;
    if (b == csvfs_pkg::QUOTE_BYTE) begin
      // opening quote of an enclosed field is swallowed
      if (at_field_start) begin
        quote_mode     = 1'b1;
        enclosed_field = 1'b1;
        at_field_start = 1'b0;
        return 1'b0;
      end
      // doubled quote collapses to one
      if (quote_waiting) begin
        quote_waiting = 1'b0;
        r.out_byte    = csvfs_pkg::QUOTE_BYTE;
        r.byte_valid  = 1'b1;
        return 1'b1;
      end
      quote_waiting = 1'b1;
      if (enclosed_field) return 1'b0;
      r.out_byte   = csvfs_pkg::QUOTE_BYTE;
      r.byte_valid = 1'b1;
      return 1'b1;
    end
    // a lone quote resolves to a toggle of quote mode
    if (quote_waiting) begin
      quote_mode    = !quote_mode;
      quote_waiting = 1'b0;
    end
    if (b == csvfs_pkg::NEWLINE_BYTE) begin
      quote_mode     = 1'b0;
      at_field_start = 1'b1;
      enclosed_field = 1'b0;
      r.field_end    = 1'b1;
      r.line_end     = 1'b1;
      return 1'b1;
    end
    if (b == separator && !quote_mode) begin
      at_field_start = 1'b1;
      enclosed_field = 1'b0;
      r.field_end    = 1'b1;
      return 1'b1;
    end
    at_field_start = 1'b0;
    r.out_byte     = b;
    r.byte_valid   = 1'b1;
    return 1'b1;
  endfunction

  initial begin
    mismatches   = 0;
    fail_count   = 0;
    results_owed = 0;
  end

  always @(posedge clk) begin
    split_result_t got;
    split_result_t want;
    if (rst) begin
      separator      = csvfs_pkg::DEFAULT_SEPARATOR;
      quote_mode     = 1'b0;
      at_field_start = 1'b1;
      enclosed_field = 1'b0;
      quote_waiting  = 1'b0;
      expected_results.delete();
    end else begin
      // compare a delivered result with the oldest prediction
      if (res.valid && res.ready) begin
        got = '{res.out_byte, res.byte_valid, res.field_end, res.line_end};
        if (expected_results.size() == 0) begin
          $error("unexpected result: out_byte %0d byte_valid %0b field_end %0b line_end %0b",
                 got.out_byte, got.byte_valid, got.field_end, got.line_end);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0d, got %0d", want.out_byte, got.out_byte);
            mismatches++;
          end
          if (got.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
            mismatches++;
          end
          if (got.field_end !== want.field_end) begin
            $error("field_end: expected %0b, got %0b", want.field_end, got.field_end);
            mismatches++;
          end
          if (got.line_end !== want.line_end) begin
            $error("line_end: expected %0b, got %0b", want.line_end, got.line_end);
            mismatches++;
          end
        end
      end
      // accepted text byte, split with the separator held before this edge
      if (src.valid && src.ready) begin
        if (split_byte(src.in_byte, want)) expected_results.push_back(want);
      end
      // separator write
      if (cfg.valid && cfg.ready) separator = cfg.data;
    end
    fail_count   <= mismatches;
    results_owed <= expected_results.size();
  end

endmodule

// ----- sim/csv_field_splitter_unit_tb.sv -----
// ----------------------------------------------------------------------------
// csv_field_splitter_unit_tb
// drives directed and random csv text through the splitter under several
// separator settings with random gaps and result stalls; the checker
// predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csv_field_splitter_unit_tb;

  logic clk;
  logic rst;
  bit   idle_on;
  int   bytes_sent;
  int   fail_count;
  int   results_owed;

  csvfs_byte_if   src_if ();
  csvfs_result_if res_if ();
  csvfs_cfg_if    cfg_if ();

  csv_field_splitter_unit uut (
    .clk (clk),
    .rst (rst),
    .src (src_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  csv_field_splitter_unit_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .src          (src_if),
    .res          (res_if),
    .cfg          (cfg_if),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // result side, stalls now and then
  always @(posedge clk) begin
    res_if.ready <= !idle_on || ($urandom_range(0, 99) >= 7);
  end

  // run limit
  initial begin
    #400000;
    $display("csv_field_splitter_unit_tb NOT OK");
    $finish;
  end

  // one text byte request, with an occasional gap before it
  task automatic send_byte(input csvfs_pkg::byte_t b);
    if (idle_on && $urandom_range(0, 99) < 7) begin
      src_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    src_if.valid   <= 1'b1;
    src_if.in_byte <= b;
    @(posedge clk);
    while (!src_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // hold off until every predicted result has come out
  task automatic wait_idle();
    src_if.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_separator(input csvfs_pkg::byte_t s);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= s;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // content byte that is neither quote, newline nor separator
  function automatic csvfs_pkg::byte_t plain_byte(input csvfs_pkg::byte_t sep);
    csvfs_pkg::byte_t b;
    do b = csvfs_pkg::byte_t'($urandom_range(0, 255));
    while (b == csvfs_pkg::QUOTE_BYTE || b == csvfs_pkg::NEWLINE_BYTE || b == sep);
    return b;
  endfunction

  // unquoted field, now and then with a stray quote inside
  task automatic send_plain_field(input csvfs_pkg::byte_t sep);
    int n;
    n = $urandom_range(0, 5);
    repeat (n) begin
      if ($urandom_range(0, 99) < 10) send_byte(csvfs_pkg::QUOTE_BYTE);
      else send_byte(plain_byte(sep));
    end
  endtask

  // enclosed field, sometimes left open or followed by stray text
  task automatic send_quoted_field(input csvfs_pkg::byte_t sep);
    int n;
    int pick;
    n = $urandom_range(0, 6);
    send_byte(csvfs_pkg::QUOTE_BYTE);
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        send_byte(csvfs_pkg::QUOTE_BYTE);
        send_byte(csvfs_pkg::QUOTE_BYTE);
      end else if (pick < 30) begin
        send_byte(sep);
      end else begin
        send_byte(plain_byte(sep));
      end
    end
    pick = $urandom_range(0, 99);
    if (pick >= 8) begin
      send_byte(csvfs_pkg::QUOTE_BYTE);
      if (pick < 15) send_byte(plain_byte(sep));
    end
  endtask

  task automatic send_line(input csvfs_pkg::byte_t sep);
    int fields;
    fields = $urandom_range(1, 4);
    for (int f = 0; f < fields; f++) begin
      if (f > 0) send_byte(sep);
      if ($urandom_range(0, 99) < 45) send_plain_field(sep);
      else send_quoted_field(sep);
    end
    send_byte(csvfs_pkg::NEWLINE_BYTE);
  endtask

  // one separator setting: mostly well-formed lines, some raw noise
  task automatic run_phase(input csvfs_pkg::byte_t sep, input int count);
    int target;
    write_separator(sep);
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      if ($urandom_range(0, 99) < 12) begin
        repeat ($urandom_range(1, 6)) send_byte(csvfs_pkg::byte_t'($urandom_range(0, 255)));
      end else begin
        send_line(sep);
      end
    end
  endtask

  // directed text: empty line, byte extremes, enclosed field with a doubled
  // quote, quotes in an unenclosed field, stray text after a closing quote,
  // and a field left open across a separator up to the newline
  csvfs_pkg::byte_t directed_text[] = '{
    csvfs_pkg::NEWLINE_BYTE,
    8'h00, 8'hFF, csvfs_pkg::DEFAULT_SEPARATOR, csvfs_pkg::NEWLINE_BYTE,
    csvfs_pkg::QUOTE_BYTE, "a", csvfs_pkg::QUOTE_BYTE, csvfs_pkg::QUOTE_BYTE, "b",
    csvfs_pkg::QUOTE_BYTE, csvfs_pkg::DEFAULT_SEPARATOR, csvfs_pkg::NEWLINE_BYTE,
    "x", csvfs_pkg::QUOTE_BYTE, "y", csvfs_pkg::QUOTE_BYTE, csvfs_pkg::NEWLINE_BYTE,
    csvfs_pkg::QUOTE_BYTE, "a", csvfs_pkg::QUOTE_BYTE, "b", csvfs_pkg::NEWLINE_BYTE,
    csvfs_pkg::QUOTE_BYTE, csvfs_pkg::DEFAULT_SEPARATOR, csvfs_pkg::NEWLINE_BYTE
  };

  initial begin
    rst            = 1'b1;
    idle_on        = 1'b1;
    bytes_sent     = 0;
    src_if.valid   = 1'b0;
    src_if.in_byte = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.data    = '0;
    res_if.ready   = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part under the reset separator
    foreach (directed_text[i]) send_byte(directed_text[i]);

    // random part over several separator settings
    run_phase(csvfs_pkg::DEFAULT_SEPARATOR, 250);
    idle_on = 1'b0;
    run_phase(8'h00, 250);
    idle_on = 1'b1;
    run_phase(8'hFF, 200);
    run_phase(csvfs_pkg::QUOTE_BYTE, 150);
    run_phase(csvfs_pkg::NEWLINE_BYTE, 150);
    run_phase(8'h09, 200);
    run_phase(csvfs_pkg::byte_t'($urandom_range(0, 255)), 150);
    run_phase(csvfs_pkg::DEFAULT_SEPARATOR, 150);

    wait_idle();
    if (fail_count == 0 && results_owed == 0) begin
      $display("csv_field_splitter_unit_tb OK");
    end else begin
      if (results_owed != 0) $error("%0d expected results never arrived", results_owed);
      $display("csv_field_splitter_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/csvfs_pkg.sv
sv/csvfs_channels.sv
sv/csv_field_splitter_unit.sv
sim/csv_field_splitter_unit_checker.sv
sim/csv_field_splitter_unit_tb.sv
